@@ rtl/circular_arena_operand_fetch_assert.svh @@
// Assertion macros shared by the circular arena operand fetch RTL.
`ifndef CIRCULAR_ARENA_OPERAND_FETCH_ASSERT_SVH
`define CIRCULAR_ARENA_OPERAND_FETCH_ASSERT_SVH

// same-cycle implication
`define CAOF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CAOF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/caof_pkg.sv @@
// Package: field widths, operation codes and controller/datapath types.
package caof_pkg;

    localparam int OP_W   = 2;
    localparam int ADDR_W = 12;
    localparam int CNT_W  = 3;
    localparam int DATA_W = 32;
    localparam int SLOT_W = 4;
    localparam int TYPE_W = 2;
    localparam int OFF_W  = 4;
    localparam int IND_W  = 16;
    localparam int BYTE_W = 8;

    localparam logic [OP_W-1:0] OP_WRITE_ARENA = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE_REG   = 2'd1;
    localparam logic [OP_W-1:0] OP_FETCH       = 2'd2;

    localparam logic [TYPE_W-1:0] ARG_REGISTER = 2'd0;
    localparam logic [TYPE_W-1:0] ARG_INDIRECT = 2'd1;
    localparam logic [TYPE_W-1:0] ARG_DIRECT4  = 2'd2;
    localparam logic [TYPE_W-1:0] ARG_DIRECT2  = 2'd3;

    localparam logic [1:0] BASE_PC  = 2'd0;
    localparam logic [1:0] BASE_AT  = 2'd1;
    localparam logic [1:0] BASE_REL = 2'd2;

    typedef struct packed {
        logic       take;
        logic       load_base;
        logic [1:0] base_sel;
        logic       norm_step;
        logic       rd_en;
        logic       wr_en;
        logic       clr_wr;
        logic       div_load;
        logic       div_step;
        logic       load_result;
        logic       reg_wr;
    } t_cmd;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [TYPE_W-1:0] arg_type;
        logic [CNT_W-1:0]  byte_count;
        logic              addr_ok;
        logic              addr_last;
        logic              div_done;
        logic              out_free;
    } t_status;

    function automatic logic [CNT_W-1:0] f_clamp_count(input logic [CNT_W-1:0] c);
        return (c > 3'd4) ? 3'd4 : c;
    endfunction

    function automatic logic [OFF_W-1:0] f_sat_offset(input logic [OFF_W:0] v);
        return (v > 5'd15) ? 4'd15 : v[OFF_W-1:0];
    endfunction

endpackage

@@ rtl/caof_if.sv @@
// Valid/ready channel interfaces for input items and result items.
interface caof_in_if;
    logic                          valid;
    logic                          ready;
    logic [caof_pkg::OP_W-1:0]     operation;
    logic [caof_pkg::ADDR_W-1:0]   address;
    logic [caof_pkg::CNT_W-1:0]    byte_count;
    logic signed [caof_pkg::DATA_W-1:0] write_data;
    logic [caof_pkg::SLOT_W-1:0]   register_slot;
    logic [caof_pkg::TYPE_W-1:0]   arg_type;
    logic [caof_pkg::OFF_W-1:0]    offset;

    modport source (
        output valid, operation, address, byte_count, write_data, register_slot,
               arg_type, offset,
        input  ready
    );
    modport sink (
        input  valid, operation, address, byte_count, write_data, register_slot,
               arg_type, offset,
        output ready
    );
endinterface

interface caof_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [caof_pkg::DATA_W-1:0] operand_value;
    logic [caof_pkg::OFF_W-1:0]         next_offset;
    logic                               bad_register;

    modport source (
        output valid, operand_value, next_offset, bad_register,
        input  ready
    );
    modport sink (
        input  valid, operand_value, next_offset, bad_register,
        output ready
    );
endinterface

@@ rtl/circular_arena_operand_fetch.sv @@
// Top level: circular byte arena with register file and operand fetch.
// One item is handled at a time. After reset the arena is cleared one byte per cycle, and
// no item is accepted until that clear pass is done. A register fetch reads 1 arena byte,
// a direct fetch 2 or 4, and an indirect fetch 2 index bytes and then 4 operand bytes.
// The single-port arena sets the pace with one byte per cycle, a fetch address outside
// the arena is brought back by one ARENA_BYTES step at a time, and the indirect remainder
// is formed by a reciprocal multiply, a back multiply and one correcting subtract. A
// finished result waits in the output register; while it is not taken the next result,
// and so the next item, stalls.
module circular_arena_operand_fetch #(
    parameter int ARENA_BYTES = 4096,
    parameter int IDX_RANGE   = 512,
    parameter int REG_COUNT   = 16
) (
    input logic         i_clk,
    input logic         i_rst_n,
    caof_in_if.sink     i_in,
    caof_out_if.source  o_out
);

    caof_pkg::t_cmd    cmd;
    caof_pkg::t_status status;
    logic              in_ready;

    assign i_in.ready = in_ready;

    caof_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    caof_dp #(
        .ARENA_BYTES (ARENA_BYTES),
        .IDX_RANGE   (IDX_RANGE),
        .REG_COUNT   (REG_COUNT)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_operation     (i_in.operation),
        .i_address       (i_in.address),
        .i_byte_count    (i_in.byte_count),
        .i_write_data    (i_in.write_data),
        .i_register_slot (i_in.register_slot),
        .i_arg_type      (i_in.arg_type),
        .i_offset        (i_in.offset),
        .i_out_ready     (o_out.ready),
        .o_out_valid     (o_out.valid),
        .o_operand_value (o_out.operand_value),
        .o_next_offset   (o_out.next_offset),
        .o_bad_register  (o_out.bad_register)
    );

endmodule

@@ rtl/caof_ctrl.sv @@
// Controller: sequences clear pass, address wrap, byte reads/writes and remainder.
`include "circular_arena_operand_fetch_assert.svh"

module caof_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  caof_pkg::t_status i_status,
    output caof_pkg::t_cmd    o_cmd
);

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_START  = 4'd2;
    localparam logic [3:0] S_NORM   = 4'd3;
    localparam logic [3:0] S_WRITE  = 4'd4;
    localparam logic [3:0] S_READ   = 4'd5;
    localparam logic [3:0] S_DRAIN  = 4'd6;
    localparam logic [3:0] S_DIVLD  = 4'd7;
    localparam logic [3:0] S_DIV    = 4'd8;
    localparam logic [3:0] S_REBASE = 4'd9;
    localparam logic [3:0] S_DONE   = 4'd10;

    logic [3:0]                 r_state, n_state;
    logic [caof_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic                       r_phase, n_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_cnt   <= '0;
            r_phase <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_phase <= n_phase;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_phase    = r_phase;
        o_cmd      = '0;
        o_in_ready = (r_state == S_IDLE);
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_status.addr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = S_START;
                end
            end
            S_START: begin
                n_phase = 1'b0;
                case (i_status.op)
                    caof_pkg::OP_WRITE_ARENA: begin
                        o_cmd.load_base = 1'b1;
                        o_cmd.base_sel  = caof_pkg::BASE_PC;
                        n_cnt           = i_status.byte_count;
                        n_state         = S_NORM;
                    end
                    caof_pkg::OP_FETCH: begin
                        o_cmd.load_base = 1'b1;
                        o_cmd.base_sel  = caof_pkg::BASE_AT;
                        case (i_status.arg_type)
                            caof_pkg::ARG_REGISTER: n_cnt = 3'd1;
                            caof_pkg::ARG_INDIRECT: n_cnt = 3'd2;
                            caof_pkg::ARG_DIRECT4:  n_cnt = 3'd4;
                            default:                n_cnt = 3'd2;
                        endcase
                        n_state = S_NORM;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_NORM: begin
                if (!i_status.addr_ok) begin
                    o_cmd.norm_step = 1'b1;
                end else if (i_status.op == caof_pkg::OP_WRITE_ARENA) begin
                    n_state = (r_cnt == 3'd0) ? S_DONE : S_WRITE;
                end else begin
                    n_state = S_READ;
                end
            end
            S_WRITE: begin
                o_cmd.wr_en = 1'b1;
                n_cnt       = r_cnt - 3'd1;
                if (r_cnt == 3'd1) begin
                    n_state = S_DONE;
                end
            end
            S_READ: begin
                o_cmd.rd_en = 1'b1;
                n_cnt       = r_cnt - 3'd1;
                if (r_cnt == 3'd1) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (i_status.arg_type == caof_pkg::ARG_INDIRECT && !r_phase) begin
                    n_state = S_DIVLD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DIVLD: begin
                o_cmd.div_load = 1'b1;
                n_state        = S_DIV;
            end
            S_DIV: begin
                if (i_status.div_done) begin
                    n_state = S_REBASE;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_REBASE: begin
                o_cmd.load_base = 1'b1;
                o_cmd.base_sel  = caof_pkg::BASE_REL;
                n_cnt           = 3'd4;
                n_phase         = 1'b1;
                n_state         = S_NORM;
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.load_result = 1'b1;
                    o_cmd.reg_wr      = (i_status.op == caof_pkg::OP_WRITE_REG);
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    `CAOF_ASSERT_IMP(a_mem_wrapped, i_clk, i_rst_n, o_cmd.rd_en || o_cmd.wr_en, i_status.addr_ok, "arena access at unwrapped address")
    `CAOF_ASSERT_NXT(a_one_item, i_clk, i_rst_n, o_cmd.take, !o_in_ready, "item accepted while one is in flight")
    `CAOF_ASSERT_IMP(a_div_indirect, i_clk, i_rst_n, r_state == S_DIV, i_status.op == caof_pkg::OP_FETCH && i_status.arg_type == caof_pkg::ARG_INDIRECT, "remainder unit busy outside indirect fetch")
    `CAOF_ASSERT_IMP(a_div_step, i_clk, i_rst_n, o_cmd.div_step, !i_status.div_done, "remainder step after completion")

endmodule

@@ rtl/caof_dp.sv @@
// Datapath: arena memory, register file, address wrap, remainder unit, result register.
module caof_dp #(
    parameter int ARENA_BYTES = 4096,
    parameter int IDX_RANGE   = 512,
    parameter int REG_COUNT   = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  caof_pkg::t_cmd                      i_cmd,
    output caof_pkg::t_status                   o_status,
    input  logic [caof_pkg::OP_W-1:0]           i_operation,
    input  logic [caof_pkg::ADDR_W-1:0]         i_address,
    input  logic [caof_pkg::CNT_W-1:0]          i_byte_count,
    input  logic signed [caof_pkg::DATA_W-1:0]  i_write_data,
    input  logic [caof_pkg::SLOT_W-1:0]         i_register_slot,
    input  logic [caof_pkg::TYPE_W-1:0]         i_arg_type,
    input  logic [caof_pkg::OFF_W-1:0]          i_offset,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic signed [caof_pkg::DATA_W-1:0]  o_operand_value,
    output logic [caof_pkg::OFF_W-1:0]          o_next_offset,
    output logic                                o_bad_register
);

    localparam int AW    = $clog2(ARENA_BYTES);
    localparam int SW    = (AW + 2 > 17) ? AW + 2 : 17;
    localparam int RIW   = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
    localparam int RSH   = 16;

    localparam logic [SW-1:0] A_X    = SW'(ARENA_BYTES);
    localparam logic [SW-1:0] A_LAST = SW'(ARENA_BYTES - 1);
    localparam logic [caof_pkg::IND_W-1:0] RECIP = caof_pkg::IND_W'((1 << RSH) / IDX_RANGE);
    localparam logic [caof_pkg::IND_W-1:0] IDX_V = caof_pkg::IND_W'(IDX_RANGE);

    // captured item
    logic [caof_pkg::OP_W-1:0]   r_op;
    logic [caof_pkg::ADDR_W-1:0] r_pc;
    logic [caof_pkg::CNT_W-1:0]  r_bcnt;
    logic [caof_pkg::DATA_W-1:0] r_data;
    logic [caof_pkg::DATA_W-1:0] r_wsh;
    logic [caof_pkg::SLOT_W-1:0] r_slot;
    logic [caof_pkg::TYPE_W-1:0] r_type;
    logic [caof_pkg::OFF_W-1:0]  r_off;

    logic [SW-1:0]               r_ext, n_ext;
    logic [SW-1:0]               base;
    logic [SW-1:0]               pc_x, off_x, rem_x, srem;
    logic                        addr_ok, addr_last;

    logic [caof_pkg::BYTE_W-1:0] r_mem [ARENA_BYTES];
    logic [caof_pkg::BYTE_W-1:0] r_q;
    logic                        r_rd_vld;
    logic [caof_pkg::DATA_W-1:0] r_acc;
    logic [caof_pkg::CNT_W-1:0]  bcnt_in;

    logic                        r_neg;
    logic [caof_pkg::IND_W-1:0]  r_rem;
    logic [31:0]                 r_prod;
    logic [1:0]                  r_dstage;

    logic [caof_pkg::DATA_W-1:0] r_regs [REG_COUNT];
    logic [caof_pkg::BYTE_W-1:0] num;
    logic                        reg_ok;
    logic [RIW-1:0]              reg_idx;

    logic                        r_ovalid;
    logic [caof_pkg::DATA_W-1:0] r_oval, res_val;
    logic [caof_pkg::OFF_W-1:0]  r_onext, res_next;
    logic                        r_obad, res_bad;

    assign bcnt_in = caof_pkg::f_clamp_count(i_byte_count);

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_op   <= i_operation;
            r_pc   <= i_address;
            r_bcnt <= bcnt_in;
            r_data <= i_write_data;
            r_slot <= i_register_slot;
            r_type <= i_arg_type;
            r_off  <= i_offset;
            case (bcnt_in)
                3'd1:    r_wsh <= i_write_data << 24;
                3'd2:    r_wsh <= i_write_data << 16;
                3'd3:    r_wsh <= i_write_data << 8;
                default: r_wsh <= i_write_data;
            endcase
        end else if (i_cmd.wr_en) begin
            r_wsh <= r_wsh << 8;
        end
    end

    // byte address, wrapped into the arena one correction per cycle
    assign pc_x      = {{(SW-caof_pkg::ADDR_W){1'b0}}, r_pc};
    assign off_x     = {{(SW-caof_pkg::OFF_W){1'b0}}, r_off};
    assign rem_x     = {{(SW-caof_pkg::IND_W){1'b0}}, r_rem};
    assign srem      = r_neg ? -rem_x : rem_x;
    assign addr_ok   = !r_ext[SW-1] && (r_ext < A_X);
    assign addr_last = (r_ext == A_LAST);

    always_comb begin
        case (i_cmd.base_sel)
            caof_pkg::BASE_PC:  base = pc_x;
            caof_pkg::BASE_AT:  base = pc_x + off_x;
            caof_pkg::BASE_REL: base = pc_x + srem;
            default:            base = pc_x;
        endcase
        n_ext = r_ext;
        if (i_cmd.load_base) begin
            n_ext = base;
        end else if (i_cmd.norm_step) begin
            n_ext = r_ext[SW-1] ? r_ext + A_X : r_ext - A_X;
        end else if (i_cmd.rd_en || i_cmd.wr_en || i_cmd.clr_wr) begin
            n_ext = addr_last ? '0 : r_ext + SW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ext    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_ext    <= n_ext;
            r_rd_vld <= i_cmd.rd_en;
        end
    end

    // single-port arena
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en || i_cmd.clr_wr) begin
            r_mem[r_ext[AW-1:0]] <= i_cmd.clr_wr ? '0 : r_wsh[31:24];
        end else if (i_cmd.rd_en) begin
            r_q <= r_mem[r_ext[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_acc <= '0;
        end else if (r_rd_vld) begin
            r_acc <= {r_acc[23:0], r_q};
        end
    end

    // truncating remainder: reciprocal multiply, back multiply, one correction
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_neg    <= r_acc[15];
            r_rem    <= r_acc[15] ? -r_acc[15:0] : r_acc[15:0];
            r_dstage <= 2'd0;
        end else if (i_cmd.div_step) begin
            r_dstage <= r_dstage + 2'd1;
            case (r_dstage)
                2'd0: begin
                    r_prod <= 32'(r_rem) * 32'(RECIP);
                end
                2'd1: begin
                    r_rem <= r_rem - caof_pkg::IND_W'(r_prod[RSH +: caof_pkg::IND_W] * IDX_V);
                end
                default: begin
                    if (r_rem >= IDX_V) begin
                        r_rem <= r_rem - IDX_V;
                    end
                end
            endcase
        end
    end

    // register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < REG_COUNT; k++) begin
                r_regs[k] <= '0;
            end
        end else if (i_cmd.reg_wr && ({3'b000, r_slot} < 7'(REG_COUNT))) begin
            r_regs[RIW'(r_slot)] <= r_data;
        end
    end

    assign num     = r_acc[7:0];
    assign reg_ok  = (num != 8'd0) && (num <= 8'(REG_COUNT));
    assign reg_idx = RIW'(num - 8'd1);

    always_comb begin
        res_val  = '0;
        res_next = '0;
        res_bad  = 1'b0;
        if (r_op == caof_pkg::OP_FETCH) begin
            case (r_type)
                caof_pkg::ARG_REGISTER: begin
                    res_val  = reg_ok ? r_regs[reg_idx] : '0;
                    res_next = reg_ok ? caof_pkg::f_sat_offset({1'b0, r_off} + 5'd1) : r_off;
                    res_bad  = !reg_ok;
                end
                caof_pkg::ARG_DIRECT4: begin
                    res_val  = r_acc;
                    res_next = caof_pkg::f_sat_offset({1'b0, r_off} + 5'd4);
                end
                default: begin
                    res_val  = r_acc;
                    res_next = caof_pkg::f_sat_offset({1'b0, r_off} + 5'd2);
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.load_result) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_result) begin
            r_oval  <= res_val;
            r_onext <= res_next;
            r_obad  <= res_bad;
        end
    end

    assign o_out_valid     = r_ovalid;
    assign o_operand_value = r_oval;
    assign o_next_offset   = r_onext;
    assign o_bad_register  = r_obad;

    assign o_status.op         = r_op;
    assign o_status.arg_type   = r_type;
    assign o_status.byte_count = r_bcnt;
    assign o_status.addr_ok    = addr_ok;
    assign o_status.addr_last  = addr_last;
    assign o_status.div_done   = (r_dstage == 2'd3);
    assign o_status.out_free   = !r_ovalid || i_out_ready;

endmodule

@@ test/circular_arena_operand_fetch_tb.sv @@
`timescale 1ns / 1ps
// Testbench for circular_arena_operand_fetch: self-checking random and directed operand fetches.
module circular_arena_operand_fetch_tb;

    localparam int ARENA_BYTES = 4096;
    localparam int IDX_RANGE   = 512;
    localparam int REG_COUNT   = 16;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 425;
    localparam int OP_W        = caof_pkg::OP_W;
    localparam int ADDR_W      = caof_pkg::ADDR_W;
    localparam int CNT_W       = caof_pkg::CNT_W;
    localparam int DATA_W      = caof_pkg::DATA_W;
    localparam int SLOT_W      = caof_pkg::SLOT_W;
    localparam int TYPE_W      = caof_pkg::TYPE_W;
    localparam int OFF_W       = caof_pkg::OFF_W;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]          operation;
        logic [ADDR_W-1:0]        address;
        logic [CNT_W-1:0]         byte_count;
        logic signed [DATA_W-1:0] write_data;
        logic [SLOT_W-1:0]        register_slot;
        logic [TYPE_W-1:0]        arg_type;
        logic [OFF_W-1:0]         offset;
    } t_fetch_req;

    typedef struct packed {
        logic signed [DATA_W-1:0] operand_value;
        logic [OFF_W-1:0]         next_offset;
        logic                     bad_register;
    } t_operand_res;

    logic i_clk = 1'b0;
    logic i_rst_n;

    caof_in_if  in_ch ();
    caof_out_if out_ch ();

    circular_arena_operand_fetch #(
        .ARENA_BYTES (ARENA_BYTES),
        .IDX_RANGE   (IDX_RANGE),
        .REG_COUNT   (REG_COUNT)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #6 i_clk = ~i_clk;

    logic [7:0]        arena_img [ARENA_BYTES];
    logic [DATA_W-1:0] reg_img [REG_COUNT];

    t_fetch_req   pending_reqs[$];
    t_operand_res expected_operands[$];
    t_fetch_req   active_req;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_req       = 0;
    int hold_ack       = 0;
    int hold_left      = 0;
    int error_count    = 0;
    int cycle_count    = 0;
    int phase_items    = 0;

    function automatic logic [DATA_W-1:0] read_be(input int start, input int count);
        logic [DATA_W-1:0] acc;
        acc = '0;
        for (int k = 0; k < count; k++)
            acc = (acc << 8) | DATA_W'(arena_img[12'(start + k)]);
        return acc;
    endfunction

    function automatic logic [OFF_W-1:0] clip_offset(input int v);
        return (v > 15) ? 4'd15 : 4'(v);
    endfunction

    // updates the arena and register images and returns the result of one item
    function automatic t_operand_res resolve_operand(input t_fetch_req r);
        t_operand_res       res;
        int                 n;
        int                 at;
        logic [7:0]         num;
        logic signed [15:0] idx;
        int                 rem;
        res = '0;
        n = (r.byte_count > 3'd4) ? 4 : int'(r.byte_count);
        case (r.operation)
            caof_pkg::OP_WRITE_ARENA: begin
                for (int k = 0; k < n; k++)
                    arena_img[12'(int'(r.address) + k)] = r.write_data[8*(n-1-k) +: 8];
            end
            caof_pkg::OP_WRITE_REG: begin
                reg_img[r.register_slot] = r.write_data;
            end
            caof_pkg::OP_FETCH: begin
                at = int'(r.address) + int'(r.offset);
                case (r.arg_type)
                    caof_pkg::ARG_REGISTER: begin
                        num = arena_img[12'(at)];
                        if (num >= 1 && num <= REG_COUNT) begin
                            res.operand_value = reg_img[num - 8'd1];
                            res.next_offset   = clip_offset(int'(r.offset) + 1);
                        end else begin
                            res.bad_register = 1'b1;
                            res.next_offset  = r.offset;
                        end
                    end
                    caof_pkg::ARG_INDIRECT: begin
                        idx = 16'(read_be(at, 2));
                        rem = idx % IDX_RANGE;
                        res.operand_value = read_be(int'(r.address) + rem, 4);
                        res.next_offset   = clip_offset(int'(r.offset) + 2);
                    end
                    caof_pkg::ARG_DIRECT4: begin
                        res.operand_value = read_be(at, 4);
                        res.next_offset   = clip_offset(int'(r.offset) + 4);
                    end
                    default: begin
                        res.operand_value = read_be(at, 2);
                        res.next_offset   = clip_offset(int'(r.offset) + 2);
                    end
                endcase
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic t_fetch_req random_req();
        t_fetch_req r;
        r.operation     = OP_W'($urandom_range(2, 0));
        r.address       = ADDR_W'($urandom_range(ARENA_BYTES - 1, 0));
        r.byte_count    = CNT_W'($urandom_range(4, 1));
        r.write_data    = $urandom;
        r.register_slot = SLOT_W'($urandom_range(15, 0));
        r.arg_type      = TYPE_W'($urandom_range(3, 0));
        r.offset        = OFF_W'($urandom_range(15, 0));
        return r;
    endfunction

    function automatic void queue_req(input t_fetch_req r);
        pending_reqs.push_back(r);
        phase_items++;
    endfunction

    function automatic void queue_arena_write(input int addr, input int cnt,
                                              input logic [DATA_W-1:0] data);
        t_fetch_req r;
        r = random_req();
        r.operation  = caof_pkg::OP_WRITE_ARENA;
        r.address    = 12'(addr);
        r.byte_count = 3'(cnt);
        r.write_data = data;
        queue_req(r);
    endfunction

    function automatic void queue_reg_write(input int slot, input logic [DATA_W-1:0] data);
        t_fetch_req r;
        r = random_req();
        r.operation     = caof_pkg::OP_WRITE_REG;
        r.register_slot = 4'(slot);
        r.write_data    = data;
        queue_req(r);
    endfunction

    function automatic void queue_fetch(input int pc, input logic [TYPE_W-1:0] kind,
                                        input int off);
        t_fetch_req r;
        r = random_req();
        r.operation = caof_pkg::OP_FETCH;
        r.address   = 12'(pc);
        r.arg_type  = kind;
        r.offset    = 4'(off);
        queue_req(r);
    endfunction

    function automatic int pick_pc();
        int roll;
        roll = $urandom_range(99, 0);
        if (roll < 12)
            return $urandom_range(15, 0);
        else if (roll < 25)
            return ARENA_BYTES - 1 - $urandom_range(15, 0);
        return $urandom_range(ARENA_BYTES - 1, 0);
    endfunction

    // one operand encoding followed by its fetch, or a stray item
    function automatic void queue_sequence();
        int                 roll;
        int                 pc;
        int                 off;
        int                 num;
        int                 rem;
        logic signed [15:0] idx;
        roll = $urandom_range(99, 0);
        pc   = pick_pc();
        off  = $urandom_range(15, 0);
        if (roll < 30) begin
            if ($urandom_range(1, 0))
                queue_reg_write($urandom_range(15, 0), $urandom);
            if ($urandom_range(99, 0) < 85)
                num = $urandom_range(REG_COUNT, 1);
            else
                num = $urandom_range(1, 0) ? 0 : $urandom_range(255, REG_COUNT + 1);
            queue_arena_write(pc + off, 1, ($urandom & 32'hFFFF_FF00) | num);
            queue_fetch(pc, caof_pkg::ARG_REGISTER, off);
        end else if (roll < 60) begin
            case ($urandom_range(2, 0))
                0: idx = 16'($urandom_range(1022, 0) - 511);
                1: idx = 16'($urandom);
                default: idx = $urandom_range(1, 0) ? 16'sh8000 + 16'($urandom_range(600, 0))
                                                    : 16'sh7FFF - 16'($urandom_range(600, 0));
            endcase
            queue_arena_write(pc + off, 2, 32'(idx));
            rem = idx % IDX_RANGE;
            if ($urandom_range(99, 0) < 80)
                queue_arena_write(pc + rem, $urandom_range(4, 1), $urandom);
            queue_fetch(pc, caof_pkg::ARG_INDIRECT, off);
        end else if (roll < 85) begin
            queue_arena_write(pc + off, $urandom_range(4, 1), $urandom);
            queue_fetch(pc, $urandom_range(1, 0) ? caof_pkg::ARG_DIRECT4
                                                 : caof_pkg::ARG_DIRECT2, off);
        end else begin
            queue_req(random_req());
        end
    endfunction

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || in_ch.valid || expected_operands.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input bit long_hold);
        @(negedge i_clk);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        phase_items    = 0;
        while (phase_items < PHASE_ITEMS)
            queue_sequence();
        if (long_hold)
            hold_req++;
        wait_drained();
    endtask

    // driver
    always @(posedge i_clk) begin
        t_fetch_req nxt;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready)
                expected_operands.push_back(resolve_operand(active_req));
            if (!in_ch.valid || in_ch.ready) begin
                if (pending_reqs.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
                    nxt = pending_reqs.pop_front();
                    active_req          <= nxt;
                    in_ch.operation     <= nxt.operation;
                    in_ch.address       <= nxt.address;
                    in_ch.byte_count    <= nxt.byte_count;
                    in_ch.write_data    <= nxt.write_data;
                    in_ch.register_slot <= nxt.register_slot;
                    in_ch.arg_type      <= nxt.arg_type;
                    in_ch.offset        <= nxt.offset;
                    in_ch.valid         <= 1'b1;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (hold_req != hold_ack) begin
            hold_left <= HOLD_CYCLES;
            hold_ack  <= hold_req;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_operand_res want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_operands.size() == 0) begin
                    $display("%0t: unexpected item: value %h next_offset %0d bad_register %b",
                             $time, out_ch.operand_value, out_ch.next_offset,
                             out_ch.bad_register);
                    error_count++;
                end else begin
                    want = expected_operands.pop_front();
                    if (out_ch.operand_value !== want.operand_value) begin
                        $display("%0t: operand_value expected %h actual %h",
                                 $time, want.operand_value, out_ch.operand_value);
                        error_count++;
                    end
                    if (out_ch.next_offset !== want.next_offset) begin
                        $display("%0t: next_offset expected %0d actual %0d",
                                 $time, want.next_offset, out_ch.next_offset);
                        error_count++;
                    end
                    if (out_ch.bad_register !== want.bad_register) begin
                        $display("%0t: bad_register expected %b actual %b",
                                 $time, want.bad_register, out_ch.bad_register);
                        error_count++;
                    end
                end
            end
            out_ch.ready <= (hold_left == 0) && ($urandom_range(99, 0) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("circular_arena_operand_fetch_tb: done, errors");
            $finish;
        end
    end

    initial begin
        t_fetch_req r;
        i_rst_n             = 1'b0;
        in_ch.valid         = 1'b0;
        in_ch.operation     = '0;
        in_ch.address       = '0;
        in_ch.byte_count    = '0;
        in_ch.write_data    = '0;
        in_ch.register_slot = '0;
        in_ch.arg_type      = '0;
        in_ch.offset        = '0;
        out_ch.ready        = 1'b0;
        for (int k = 0; k < ARENA_BYTES; k++)
            arena_img[k] = '0;
        for (int k = 0; k < REG_COUNT; k++)
            reg_img[k] = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed
        queue_fetch(0, caof_pkg::ARG_DIRECT4, 0);
        queue_arena_write(ARENA_BYTES - 2, 4, 32'h80FF_7F01);
        queue_fetch(ARENA_BYTES - 2, caof_pkg::ARG_DIRECT4, 0);
        queue_fetch(ARENA_BYTES - 16, caof_pkg::ARG_DIRECT2, 15);
        queue_reg_write(0, 32'h7FFF_FFFF);
        queue_reg_write(15, 32'h8000_0000);
        queue_arena_write(100, 1, 32'h0000_0001);
        queue_fetch(100, caof_pkg::ARG_REGISTER, 0);
        queue_arena_write(101, 1, 32'h0000_0010);
        queue_fetch(96, caof_pkg::ARG_REGISTER, 5);
        queue_arena_write(102, 1, 32'hFFFF_FF00);
        queue_fetch(102, caof_pkg::ARG_REGISTER, 0);
        queue_arena_write(103, 1, 32'h0000_0011);
        queue_fetch(90, caof_pkg::ARG_REGISTER, 13);
        queue_arena_write(104, 1, 32'hFFFF_FFFF);
        queue_fetch(89, caof_pkg::ARG_REGISTER, 15);
        // negative remainder wraps below address zero
        queue_arena_write(10, 2, 32'h0000_FE01);
        queue_arena_write(10 - 511, 4, 32'hDEAD_BEEF);
        queue_fetch(10, caof_pkg::ARG_INDIRECT, 0);
        queue_arena_write(4014, 2, 32'h0000_7FFF);
        queue_arena_write(4000 + 511, 4, 32'h0123_4567);
        queue_fetch(4000, caof_pkg::ARG_INDIRECT, 14);
        queue_arena_write(200, 0, 32'hA5A5_A5A5);
        queue_arena_write(300, 7, 32'h89AB_CDEF);
        queue_fetch(300, caof_pkg::ARG_DIRECT4, 0);
        queue_fetch(198, caof_pkg::ARG_DIRECT4, 2);
        r = random_req();
        r.operation = OP_UNUSED;
        queue_req(r);
        wait_drained();

        run_phase(0, 0, 1'b1);
        run_phase(67, 0, 1'b0);
        run_phase(0, 67, 1'b0);
        run_phase(6, 6, 1'b0);

        repeat (40) @(posedge i_clk);
        if (error_count == 0 && expected_operands.size() == 0)
            $display("circular_arena_operand_fetch_tb: done, clean");
        else
            $display("circular_arena_operand_fetch_tb: done, errors");
        $finish;
    end
endmodule
